// ----- hdl/pli_pkg.sv -----
// Shared types and constants for the piecewise linear interpolator.
// No dependencies.
`default_nettype none
package pli_pkg;
  localparam int NODES_DEF = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_Q_RD0,
    S_Q_RD1,
    S_Q_LD,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator over a sorted table of up to NODES signed
// Q16.16 (x,y) nodes held in two synchronous RAMs. Items are taken one at a
// time. An add scans the stored x values and shifts the nodes above the
// insert point up. A query scans the table, reads the upper neighbor, forms
// the exact 33x32 product and runs a restoring divider. Refused commands
// finish after the scan or at once. One result item leaves per input item
// through an output register, so the next item is taken while it waits;
// a finished item whose result finds the register still full holds the
// sequencer in its output state, adding the receiver's stall cycles.
// Depends on pli_pkg, pli_seq, pli_ram, pli_div.
`default_nettype none
module piecewise_linear_interpolator #(
  parameter int NODES = pli_pkg::NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command [1:0], node_x [33:2], node_y [65:34], query_x [97:66], zeros above
  input  wire logic [103:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status [1:0], value [33:2], zeros above
  output logic [39:0]      out_tdata
);
  logic        busy, done, start, hold;
  logic [1:0]  res_status;
  logic [31:0] res_value;
  logic        ov_r, ov_nxt;
  logic [33:0] od_r, od_nxt;

  // Take a new item only when the sequencer is idle.
  assign in_tready = !busy && !(ov_r && done);
  assign start     = in_tvalid && in_tready;
  // Keep the sequencer's result back while the slot is full and not draining.
  assign hold      = ov_r && !out_tready;

  pli_seq #(.NODES(NODES)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .hold(hold), .cmd(in_tdata[1:0]),
    .nx(in_tdata[33:2]), .ny(in_tdata[65:34]), .qx(in_tdata[97:66]),
    .busy(busy), .done(done), .res_status(res_status), .res_value(res_value));

  // Hold the result until taken; the sequencer only finishes when the slot
  // is empty or draining in this same cycle.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    if (done) begin
      ov_nxt = 1'b1;
      od_nxt = {res_value, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= ov_nxt;
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, od_r};
endmodule
`default_nettype wire

// ----- hdl/pli_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/pli_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pli_pkg.
`default_nettype none
module pli_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic      [63:0] quotient,
  output pli_pkg::div_ctl_t ctl
);
  logic [63:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] trial;
  logic [34:0] diff;

  always_comb begin
    trial    = {rem_r[32:0], q_r[63]};
    diff     = {1'b0, trial} - {2'b00, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[34]) begin
        rem_nxt = diff[33:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient  = q_r;
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
endmodule
`default_nettype wire

// ----- hdl/pli_seq.sv -----
// Command sequencer: scans, shifts and reads the node memories, runs queries.
// Depends on pli_pkg, pli_ram and pli_div.
`default_nettype none
module pli_seq #(
  parameter int NODES = pli_pkg::NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        hold,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] nx,
  input  wire logic [31:0] ny,
  input  wire logic [31:0] qx,
  output logic             busy,
  output logic             done,
  output logic [1:0]       res_status,
  output logic [31:0]      res_value
);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);

  pli_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          bad_r, bad_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          dup_r, dup_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   ax_r, ax_nxt, ay_r, ay_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   x0_r, x0_nxt, y0_r, y0_nxt;
  logic [32:0]   dx_r, dx_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [32:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic          dstart;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wx, wy, rx, ry;
  logic [63:0]   quo;
  pli_pkg::div_ctl_t dctl;

  pli_ram #(.WIDTH(32), .DEPTH(NODES)) u_xram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rx));
  pli_ram #(.WIDTH(32), .DEPTH(NODES)) u_yram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(ry));
  pli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(prod_r),
    .divisor(dx_r), .quotient(quo), .ctl(dctl));

  logic signed [65:0] sum;
  logic [CW-1:0] last;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; bad_nxt = bad_r; idx_nxt = idx_r;
    pos_nxt = pos_r; dup_nxt = dup_r; cmd_nxt = cmd_r; ax_nxt = ax_r;
    ay_nxt = ay_r; stat_nxt = stat_r; val_nxt = val_r; x0_nxt = x0_r;
    y0_nxt = y0_r; dx_nxt = dx_r; off_nxt = off_r; mag_nxt = mag_r;
    neg_nxt = neg_r; prod_nxt = prod_r;
    dstart = 1'b0; we = 1'b0; waddr = '0; wx = rx; wy = ry; raddr = '0;
    done = 1'b0;
    last = cnt_r - CW'(1);
    sum = '0;
    case (st_r)
      pli_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd; ax_nxt = nx; ay_nxt = ny; stat_nxt = pli_pkg::ST_OK;
          val_nxt = '0; idx_nxt = '0; pos_nxt = '0; dup_nxt = 1'b0;
          st_nxt = pli_pkg::S_OUT;
          case (pli_pkg::cmd_t'(cmd))
            pli_pkg::CMD_CLEAR: begin
              cnt_nxt = '0; bad_nxt = 1'b0;
            end
            pli_pkg::CMD_ADD: begin
              if (cnt_r >= CW'(NODES)) stat_nxt = pli_pkg::ST_FULL;
              else if (cnt_r == '0) st_nxt = pli_pkg::S_PUT;
              else st_nxt = pli_pkg::S_SCAN;
            end
            pli_pkg::CMD_QUERY: begin
              ax_nxt = qx;
              if (bad_r) stat_nxt = pli_pkg::ST_DUP;
              else if (cnt_r < CW'(2)) stat_nxt = pli_pkg::ST_RANGE;
              else st_nxt = pli_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      // Issue reads of entries 0..cnt-1 one at a time; compare each returned one before the next read.
      pli_pkg::S_SCAN: begin
        raddr = idx_r[AW-1:0];
        st_nxt = pli_pkg::S_SCAN_WAIT;
      end
      pli_pkg::S_SCAN_WAIT: begin
        if (cmd_r == pli_pkg::CMD_ADD) begin
          if ($signed(rx) == $signed(ax_r)) dup_nxt = 1'b1;
          if ($signed(rx) < $signed(ax_r)) pos_nxt = idx_r + CW'(1);
        end else begin
          if (idx_r == '0 && $signed(ax_r) < $signed(rx)) begin
            stat_nxt = pli_pkg::ST_RANGE;
          end
          if ($signed(rx) <= $signed(ax_r)) begin
            pos_nxt = idx_r; x0_nxt = rx; y0_nxt = ry;
          end
          if (idx_r == last && $signed(ax_r) > $signed(rx)) begin
            stat_nxt = pli_pkg::ST_RANGE;
          end
        end
        if (idx_r == last) begin
          if (cmd_r == pli_pkg::CMD_ADD) begin
            if (dup_nxt) begin
              bad_nxt = 1'b1; stat_nxt = pli_pkg::ST_DUP; st_nxt = pli_pkg::S_OUT;
            end else begin
              idx_nxt = cnt_r;
              st_nxt = (cnt_r == pos_nxt) ? pli_pkg::S_PUT : pli_pkg::S_SHIFT_RD;
            end
          end else if (stat_nxt != pli_pkg::ST_OK) begin
            st_nxt = pli_pkg::S_OUT;
          end else if (x0_nxt == ax_r) begin
            val_nxt = y0_nxt; st_nxt = pli_pkg::S_OUT;
          end else begin
            st_nxt = pli_pkg::S_Q_RD0;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          st_nxt = pli_pkg::S_SCAN;
        end
      end
      // Move entry idx-1 up to idx, down to pos.
      pli_pkg::S_SHIFT_RD: begin
        raddr = AW'(idx_r - CW'(1));
        st_nxt = pli_pkg::S_SHIFT_WR;
      end
      pli_pkg::S_SHIFT_WR: begin
        we = 1'b1; waddr = idx_r[AW-1:0];
        idx_nxt = idx_r - CW'(1);
        st_nxt = (idx_nxt == pos_r) ? pli_pkg::S_PUT : pli_pkg::S_SHIFT_RD;
      end
      pli_pkg::S_PUT: begin
        we = 1'b1; waddr = pos_r[AW-1:0]; wx = ax_r; wy = ay_r;
        cnt_nxt = cnt_r + CW'(1);
        st_nxt = pli_pkg::S_OUT;
      end
      pli_pkg::S_Q_RD0: begin
        raddr = AW'(pos_r + CW'(1));
        st_nxt = pli_pkg::S_Q_RD1;
      end
      // Keep the upper neighbor's address so its data is still there at load.
      pli_pkg::S_Q_RD1: begin
        raddr = AW'(pos_r + CW'(1));
        st_nxt = pli_pkg::S_Q_LD;
      end
      pli_pkg::S_Q_LD: begin
        raddr = AW'(pos_r + CW'(1));
        dx_nxt = 33'($signed(rx) - $signed(x0_r));
        off_nxt = ax_r - x0_r;
        neg_nxt = $signed(ry) < $signed(y0_r);
        mag_nxt = neg_nxt ? 33'($signed(y0_r) - $signed(ry))
                          : 33'($signed(ry) - $signed(y0_r));
        st_nxt = pli_pkg::S_MUL;
      end
      pli_pkg::S_MUL: begin
        prod_nxt = 64'({31'b0, mag_r} * {32'b0, off_r});
        st_nxt = pli_pkg::S_DIV;
        dstart = 1'b0;
      end
      pli_pkg::S_DIV: begin
        if (!dctl.busy && !dctl.done && idx_r != '1) begin
          dstart = 1'b1; idx_nxt = '1;
        end
        if (dctl.done) st_nxt = pli_pkg::S_FIN;
      end
      pli_pkg::S_FIN: begin
        sum = neg_r ? $signed({{34{y0_r[31]}}, y0_r}) - $signed({2'b00, quo})
                    : $signed({{34{y0_r[31]}}, y0_r}) + $signed({2'b00, quo});
        if (sum > 66'sd2147483647) val_nxt = 32'h7FFF_FFFF;
        else if (sum < -66'sd2147483648) val_nxt = 32'h8000_0000;
        else val_nxt = sum[31:0];
        st_nxt = pli_pkg::S_OUT;
      end
      // Hold here while the output register is still full and not draining.
      pli_pkg::S_OUT: begin
        if (!hold) begin
          done = 1'b1;
          st_nxt = pli_pkg::S_IDLE;
        end
      end
      default: st_nxt = pli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pli_pkg::S_IDLE; cnt_r <= '0; bad_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; bad_r <= bad_nxt;
    end
    idx_r <= idx_nxt; pos_r <= pos_nxt; dup_r <= dup_nxt; cmd_r <= cmd_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; stat_r <= stat_nxt; val_r <= val_nxt;
    x0_r <= x0_nxt; y0_r <= y0_nxt; dx_r <= dx_nxt; off_r <= off_nxt;
    mag_r <= mag_nxt; neg_r <= neg_nxt; prod_r <= prod_nxt;
  end

  assign busy       = (st_r != pli_pkg::S_IDLE);
  assign res_status = stat_r;
  assign res_value  = val_r;
endmodule
`default_nettype wire

// ----- hdl/pli_checker.sv -----
// Port-level checker for the interpolator, bound to the top level.
// Depends on pli_pkg status codes.
`default_nettype none
module pli_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [103:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken during work");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != pli_pkg::ST_OK |-> out_tdata[33:2] == '0)
    else $error("nonzero value with error status");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == '0)
    else $error("padding bits set");
endmodule

bind piecewise_linear_interpolator pli_checker u_chk (.*);
`default_nettype wire

// ----- test/piecewise_linear_interpolator_tb.sv -----
// Self-checking testbench for piecewise_linear_interpolator: directed table, then random
// add/query/clear traffic, each result checked against a typed answer or a behavioral table model.
// Depends on pli_pkg and the RTL of the interpolator.
`default_nettype none
module piecewise_linear_interpolator_tb;

  localparam int NODES = pli_pkg::NODES_DEF;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // command [1:0], node_x [33:2], node_y [65:34], query_x [97:66], zeros above
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // status [1:0], value [33:2], zeros above
  logic [39:0]  out_tdata;

  typedef struct packed {
    pli_pkg::status_t status;
    logic [31:0]      value;
  } answer_t;

  typedef struct {
    pli_pkg::cmd_t cmd;
    logic [31:0]   nx;
    logic [31:0]   ny;
    logic [31:0]   qx;
    logic          known;   // answer typed in the row
    answer_t       ans;
  } row_t;

  // Mirror of the node table.
  logic signed [31:0] tab_x [NODES];
  logic signed [31:0] tab_y [NODES];
  int                 tab_n;
  logic               tab_bad;

  answer_t answers_due [$];
  int      errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      n_sent;

  piecewise_linear_interpolator #(.NODES(NODES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Evaluate one command against the mirror and advance it.
  function automatic answer_t interpolate(pli_pkg::cmd_t cmd, logic signed [31:0] nx,
                                          logic signed [31:0] ny,
                                          logic signed [31:0] qx);
    answer_t     a;
    int          pos;
    int          k;
    logic        dup;
    logic signed [63:0] dy;
    logic        [63:0] mag;
    logic        [63:0] dx;
    logic        [63:0] off;
    logic        [63:0] q;
    logic signed [63:0] r;
    a.status = pli_pkg::ST_OK;
    a.value  = '0;
    pos = 0;
    k = 0;
    dup = 1'b0;
    case (cmd)
      pli_pkg::CMD_CLEAR: begin
        tab_n = 0;
        tab_bad = 1'b0;
      end
      pli_pkg::CMD_ADD: begin
        if (tab_n >= NODES) begin
          a.status = pli_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < tab_n; i++) begin
            if (tab_x[i] == nx) dup = 1'b1;
            if (tab_x[i] < nx) pos = i + 1;
          end
          if (dup) begin
            tab_bad = 1'b1;
            a.status = pli_pkg::ST_DUP;
          end else begin
            for (int i = tab_n; i > pos; i--) begin
              tab_x[i] = tab_x[i-1];
              tab_y[i] = tab_y[i-1];
            end
            tab_x[pos] = nx;
            tab_y[pos] = ny;
            tab_n++;
          end
        end
      end
      pli_pkg::CMD_QUERY: begin
        if (tab_bad) begin
          a.status = pli_pkg::ST_DUP;
        end else if (tab_n < 2 || qx < tab_x[0] || qx > tab_x[tab_n-1]) begin
          a.status = pli_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < tab_n; i++)
            if (tab_x[i] <= qx) k = i;
          if (tab_x[k] == qx) begin
            a.value = tab_y[k];
          end else begin
            // Exact product of |dy| and the offset, then a truncating divide.
            dy  = 64'(tab_y[k+1]) - 64'(tab_y[k]);
            mag = (dy < 0) ? 64'(-dy) : 64'(dy);
            dx  = 64'(64'(tab_x[k+1]) - 64'(tab_x[k]));
            off = 64'(64'(qx) - 64'(tab_x[k]));
            q   = (mag * off) / dx;
            r   = (dy < 0) ? 64'(tab_y[k]) - $signed(q) : 64'(tab_y[k]) + $signed(q);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            a.value = r[31:0];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Present one item, hold until taken, record its answer. Valid stays up
  // after the accepting edge so back-to-back items need no gap.
  task automatic send_item(pli_pkg::cmd_t cmd, logic [31:0] nx, logic [31:0] ny,
                           logic [31:0] qx, logic known, answer_t typed);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    a = interpolate(cmd, nx, ny, qx);
    if (known && a !== typed)
      $display("%0t row answer mismatch: table %h, predicted %h", $time, typed, a);
    answers_due = {answers_due, (known ? typed : a)};
    n_sent++;
    in_tdata  <= {6'b0, qx, ny, nx, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid so nothing more is taken while the sender waits.
  task automatic release_bus();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, compare each taken item with the oldest answer due.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          $display("%0t unexpected result: got status %0d value %h", $time,
                   out_tdata[1:0], out_tdata[33:2]);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (out_tdata[1:0] !== want.status || out_tdata[33:2] !== want.value) begin
            $display("%0t mismatch: expected status %0d value %h, got status %0d value %h",
                     $time, want.status, want.value, out_tdata[1:0], out_tdata[33:2]);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  row_t rows [$];

  task automatic add_row(pli_pkg::cmd_t c, logic [31:0] nx, logic [31:0] ny,
                         logic [31:0] qx, logic k, pli_pkg::status_t s, logic [31:0] v);
    row_t r;
    r.cmd = c; r.nx = nx; r.ny = ny; r.qx = qx; r.known = k;
    r.ans.status = s; r.ans.value = v;
    rows = {rows, r};
  endtask

  initial begin
    answer_t blank;
    pli_pkg::cmd_t c;
    int      sent;
    logic [31:0] base;
    blank = '0;
    errors = 0;
    n_sent = 0;
    tab_n = 0;
    tab_bad = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Directed table.
    // empty table
    add_row(pli_pkg::CMD_QUERY, 0, 0, 0, 1, pli_pkg::ST_RANGE, 0);
    add_row(pli_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, pli_pkg::ST_OK, 0);
    // one node
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h8000_0000, 1, pli_pkg::ST_RANGE, 0);
    add_row(pli_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, pli_pkg::ST_OK, 0);
    // exact hits on both ends
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h8000_0000, 1, pli_pkg::ST_OK, 32'h7FFF_FFFF);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h7FFF_FFFF, 1, pli_pkg::ST_OK, 32'h8000_0000);
    // widest span
    add_row(pli_pkg::CMD_QUERY, 0, 0, 0, 0, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h0000_1234, 0, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_CLEAR, 0, 0, 0, 1, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_ADD, 32'h0001_0000, 32'h7FFF_0000, 0, 1, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_ADD, 32'hFFFF_0000, 32'h8001_0000, 0, 1, pli_pkg::ST_OK, 0);
    // mid insert
    add_row(pli_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0005, 0, 1, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h0000_8000, 0, pli_pkg::ST_OK, 0);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'hFFFF_4000, 0, pli_pkg::ST_OK, 0);
    // above last, below first
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h0001_0001, 1, pli_pkg::ST_RANGE, 0);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'hFFFE_FFFF, 1, pli_pkg::ST_RANGE, 0);
    // duplicate, then a query on the bad table
    add_row(pli_pkg::CMD_ADD, 32'h0000_0000, 32'h1111_1111, 0, 1, pli_pkg::ST_DUP, 0);
    add_row(pli_pkg::CMD_QUERY, 0, 0, 32'h0000_0000, 1, pli_pkg::ST_DUP, 0);
    add_row(pli_pkg::CMD_CLEAR, 0, 0, 0, 1, pli_pkg::ST_OK, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].nx, rows[i].ny, rows[i].qx, rows[i].known, rows[i].ans);

    // Fill the table to the brim and push past it.
    for (int i = 0; i <= NODES; i++)
      send_item(pli_pkg::CMD_ADD, 32'(i * 7919 - 200000), $urandom, 0, 0, blank);
    send_item(pli_pkg::CMD_QUERY, 0, 0, 32'(30 * 7919 - 190000), 0, blank);
    send_item(pli_pkg::CMD_ADD, 32'h7FFF_FFFF, 0, 0, 1, '{pli_pkg::ST_FULL, 32'h0});

    // Hold off until every answer has arrived.
    release_bus();
    while (answers_due.size() != 0) @(posedge clk);

    // Random part: build small tables and query them, phase by phase.
    sent = n_sent;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int s = 0; s < 120; s++) begin
        c = pli_pkg::cmd_t'($urandom_range(3));
        if ($urandom_range(9) < 8) begin
          // Well-formed: a clear one time in four, a few adds, then a query in range where possible and a random one.
          if ($urandom_range(3) == 0)
            send_item(pli_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 0, blank);
          base = rand_word();
          for (int j = $urandom_range(1, 5); j > 0; j--)
            send_item(pli_pkg::CMD_ADD, ($urandom_range(3) == 0) ? rand_word()
                      : base + $urandom_range(1 << 20), rand_word(), 0, 0, blank);
          if (tab_n >= 2 && !tab_bad)
            send_item(pli_pkg::CMD_QUERY, $urandom, $urandom,
                      tab_x[0] + 32'($urandom_range(0, 32'(tab_x[tab_n-1] - tab_x[0]))),
                      0, blank);
          else
            send_item(pli_pkg::CMD_QUERY, $urandom, $urandom, rand_word(), 0, blank);
          send_item(pli_pkg::CMD_QUERY, $urandom, $urandom, rand_word(), 0, blank);
        end else begin
          send_item(c, rand_word(), rand_word(), rand_word(), 0, blank);
        end
        if (n_sent - sent >= 100 * (ph + 1)) break;
      end
    end

    release_bus();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
